@@ src/odcd_pkg.sv @@
`timescale 1ns / 1ps

package odcd_pkg;

    localparam int HEADER_CAP_DEF = 200;
    localparam int NAME_CHARS_DEF = 15;

    localparam logic [7:0]  BYTE_ESC   = 8'h1B;
    localparam logic [7:0]  BYTE_BEL   = 8'h07;
    localparam logic [7:0]  BYTE_CLOSE = 8'h5D;
    localparam logic [30:0] SIZE_MAX   = 31'h7FFF_FFFF;

    localparam int PREFIX_LEN       = 5;
    localparam int CARRIER_LEN      = 10;
    localparam int DEFAULT_NAME_LEN = 8;

    typedef enum logic [1:0] {
        ESC_NORMAL,
        ESC_AFTER,
        ESC_HEADER
    } esc_mode_t;

    typedef enum logic [1:0] {
        NUM_SKIP,
        NUM_SIGN,
        NUM_DIGITS,
        NUM_DONE
    } num_phase_t;

    typedef enum logic [1:0] {
        KIND_CONSOLE,
        KIND_BODY,
        KIND_START,
        KIND_NAME
    } kind_t;

    typedef enum logic [1:0] {
        CMD_SINGLE,
        CMD_ESC_PAIR,
        CMD_START
    } cmd_type_t;

    // One queued command: a single result, an escape pair, or a download start.
    typedef struct packed {
        cmd_type_t   ctype;
        kind_t       kind;
        logic [7:0]  data;
        logic        body_end;
        logic        lost;
        logic [30:0] size;
    } cmd_t;

    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = "5";
            3'd1:    ch = "1";
            3'd2:    ch = "1";
            3'd3:    ch = "3";
            default: ch = ";";
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] carrier_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = "N";
            4'd1:    ch = "O";
            4'd2:    ch = " ";
            4'd3:    ch = "C";
            4'd4:    ch = "A";
            4'd5:    ch = "R";
            4'd6:    ch = "R";
            4'd7:    ch = "I";
            4'd8:    ch = "E";
            default: ch = "R";
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] default_name_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = "d";
            3'd1:    ch = "o";
            3'd2:    ch = "w";
            3'd3:    ch = "n";
            3'd4:    ch = "l";
            3'd5:    ch = "o";
            3'd6:    ch = "a";
            default: ch = "d";
        endcase
        return ch;
    endfunction

endpackage

@@ src/odcd_in_if.sv @@
`timescale 1ns / 1ps

interface odcd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ src/odcd_out_if.sv @@
`timescale 1ns / 1ps

interface odcd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [30:0] body_size;
    logic        body_end;
    logic        carrier_lost;
    logic        last;

    modport source (output valid, output kind, output data_byte, output body_size,
                    output body_end, output carrier_lost, output last, input ready);
    modport sink   (input valid, input kind, input data_byte, input body_size,
                    input body_end, input carrier_lost, input last, output ready);
endinterface

@@ src/odcd_front.sv @@
`timescale 1ns / 1ps

module odcd_front #(
    parameter int HEADER_CAP = odcd_pkg::HEADER_CAP_DEF,
    parameter int NAME_CHARS = odcd_pkg::NAME_CHARS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    odcd_in_if.sink                           rx,
    input  logic                              q_ready,
    output logic                              q_push,
    output odcd_pkg::cmd_t                    q_cmd,
    input  logic                              start_done,
    input  logic [$clog2(NAME_CHARS)-1:0]     name_rd_idx,
    output logic [7:0]                        name_char,
    output logic [$clog2(NAME_CHARS+1)-1:0]   name_len
);
    import odcd_pkg::*;

    localparam int HCW = $clog2(HEADER_CAP);
    localparam int IW  = $clog2(NAME_CHARS);
    localparam int NLW = $clog2(NAME_CHARS + 1);

    esc_mode_t   esc_reg, esc_next;
    logic [HCW-1:0] hcount_reg, hcount_next;
    logic        prefix_ok_reg, prefix_ok_next;
    num_phase_t  phase_reg, phase_next;
    logic        neg_reg, neg_next;
    logic [30:0] acc_reg, acc_next;
    logic        sep_reg, sep_next;
    logic        ended_reg, ended_next;
    logic [NLW-1:0] nlen_reg, nlen_next;
    logic [30:0] left_reg, left_next;
    logic [3:0]  carrier_reg, carrier_next;
    logic        busy_reg, busy_next;

    logic [7:0]  name_store [NAME_CHARS];
    logic [7:0]  name_char_reg;
    logic        store_we;

    logic        accept;
    logic [7:0]  c;
    logic        is_digit;
    logic        is_space;
    logic        run_digit;
    logic [34:0] acc_wide;
    logic [3:0]  cidx;

    assign c         = rx.rx_byte;
    assign rx.ready  = q_ready && !busy_reg;
    assign accept    = rx.valid && rx.ready;
    assign is_digit  = (c >= "0") && (c <= "9");
    assign is_space  = (c == " ") || (c inside {[8'h09:8'h0D]});
    assign acc_wide  = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                     + {31'd0, c[3:0] - 4'd0};
    assign cidx      = (carrier_reg >= 4'(CARRIER_LEN)) ? 4'd0 : carrier_reg;

    assign name_char = name_char_reg;
    assign name_len  = nlen_reg;

    always_comb
    begin
        esc_next       = esc_reg;
        hcount_next    = hcount_reg;
        prefix_ok_next = prefix_ok_reg;
        phase_next     = phase_reg;
        neg_next       = neg_reg;
        acc_next       = acc_reg;
        sep_next       = sep_reg;
        ended_next     = ended_reg;
        nlen_next      = nlen_reg;
        left_next      = left_reg;
        carrier_next   = carrier_reg;
        busy_next      = busy_reg && !start_done;
        store_we       = 1'b0;
        run_digit      = 1'b0;
        q_push         = 1'b0;
        q_cmd.ctype    = CMD_SINGLE;
        q_cmd.kind     = KIND_CONSOLE;
        q_cmd.data     = c;
        q_cmd.body_end = 1'b0;
        q_cmd.lost     = 1'b0;
        q_cmd.size     = '0;

        if (accept)
        begin
            if (left_reg != '0)
            begin
                // Body capture swallows every byte, escape codes included.
                left_next      = left_reg - 31'd1;
                q_push         = 1'b1;
                q_cmd.kind     = KIND_BODY;
                q_cmd.body_end = (left_reg == 31'd1);
            end
            else
            begin
                case (esc_reg)
                    ESC_NORMAL:
                    begin
                        if (c == BYTE_ESC)
                        begin
                            esc_next = ESC_AFTER;
                        end
                        else
                        begin
                            q_push = 1'b1;
                            if (c == carrier_char(cidx))
                            begin
                                if (cidx == 4'(CARRIER_LEN - 1))
                                begin
                                    carrier_next = 4'd0;
                                    q_cmd.lost   = 1'b1;
                                end
                                else
                                begin
                                    carrier_next = cidx + 4'd1;
                                end
                            end
                            else
                            begin
                                carrier_next = (c == "N") ? 4'd1 : 4'd0;
                            end
                        end
                    end
                    ESC_AFTER:
                    begin
                        if (c == BYTE_CLOSE)
                        begin
                            esc_next       = ESC_HEADER;
                            hcount_next    = '0;
                            prefix_ok_next = 1'b1;
                            phase_next     = NUM_SKIP;
                            neg_next       = 1'b0;
                            acc_next       = '0;
                            sep_next       = 1'b0;
                            ended_next     = 1'b0;
                            nlen_next      = '0;
                        end
                        else
                        begin
                            esc_next    = ESC_NORMAL;
                            q_push      = 1'b1;
                            q_cmd.ctype = CMD_ESC_PAIR;
                        end
                    end
                    ESC_HEADER:
                    begin
                        if (c == BYTE_BEL)
                        begin
                            esc_next = ESC_NORMAL;
                            if (prefix_ok_reg && (hcount_reg > HCW'(PREFIX_LEN)) && !neg_reg
                                && (acc_reg != '0))
                            begin
                                q_push      = 1'b1;
                                q_cmd.ctype = CMD_START;
                                q_cmd.kind  = KIND_START;
                                q_cmd.data  = 8'd0;
                                q_cmd.size  = acc_reg;
                                left_next   = acc_reg;
                                busy_next   = 1'b1;
                            end
                        end
                        else if (hcount_reg < HCW'(HEADER_CAP - 1))
                        begin
                            hcount_next = hcount_reg + HCW'(1);
                            if (hcount_reg < HCW'(PREFIX_LEN))
                            begin
                                if (c != prefix_char(hcount_reg[2:0]))
                                begin
                                    prefix_ok_next = 1'b0;
                                end
                            end
                            else if (!ended_reg)
                            begin
                                if (c == 8'd0)
                                begin
                                    ended_next = 1'b1;
                                end
                                else
                                begin
                                    case (phase_reg)
                                        NUM_SKIP:
                                        begin
                                            if (!is_space)
                                            begin
                                                if ((c == "+") || (c == "-"))
                                                begin
                                                    neg_next   = (c == "-");
                                                    phase_next = NUM_SIGN;
                                                end
                                                else
                                                begin
                                                    run_digit = 1'b1;
                                                end
                                            end
                                        end
                                        NUM_SIGN, NUM_DIGITS:
                                        begin
                                            run_digit = 1'b1;
                                        end
                                        default:
                                        begin
                                            run_digit = 1'b0;
                                        end
                                    endcase
                                    if (run_digit)
                                    begin
                                        if (is_digit)
                                        begin
                                            acc_next   = (acc_wide > {4'd0, SIZE_MAX}) ?
                                                         SIZE_MAX : acc_wide[30:0];
                                            phase_next = NUM_DIGITS;
                                        end
                                        else
                                        begin
                                            phase_next = NUM_DONE;
                                        end
                                    end
                                    if (sep_reg)
                                    begin
                                        if (nlen_reg < NLW'(NAME_CHARS))
                                        begin
                                            store_we  = 1'b1;
                                            nlen_next = nlen_reg + NLW'(1);
                                        end
                                    end
                                    else if (c == ";")
                                    begin
                                        sep_next = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                    default:
                    begin
                        esc_next = ESC_NORMAL;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg       <= ESC_NORMAL;
            hcount_reg    <= '0;
            prefix_ok_reg <= 1'b0;
            phase_reg     <= NUM_SKIP;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
            sep_reg       <= 1'b0;
            ended_reg     <= 1'b0;
            nlen_reg      <= '0;
            left_reg      <= '0;
            carrier_reg   <= 4'd0;
            busy_reg      <= 1'b0;
        end
        else
        begin
            esc_reg       <= esc_next;
            hcount_reg    <= hcount_next;
            prefix_ok_reg <= prefix_ok_next;
            phase_reg     <= phase_next;
            neg_reg       <= neg_next;
            acc_reg       <= acc_next;
            sep_reg       <= sep_next;
            ended_reg     <= ended_next;
            nlen_reg      <= nlen_next;
            left_reg      <= left_next;
            carrier_reg   <= carrier_next;
            busy_reg      <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            name_store[nlen_reg[IW-1:0]] <= c;
        end
        name_char_reg <= name_store[name_rd_idx];
    end

endmodule

@@ src/odcd_queue.sv @@
`timescale 1ns / 1ps

module odcd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  odcd_pkg::cmd_t  push_cmd,
    output logic            push_ready,
    input  logic            pop,
    output logic            head_valid,
    output odcd_pkg::cmd_t  head_cmd
);
    import odcd_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign push_ready = (count_reg != 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ src/odcd_back.sv @@
`timescale 1ns / 1ps

module odcd_back #(
    parameter int NAME_CHARS = odcd_pkg::NAME_CHARS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              head_valid,
    input  odcd_pkg::cmd_t                    head_cmd,
    output logic                              pop,
    output logic                              start_done,
    output logic [$clog2(NAME_CHARS)-1:0]     name_rd_idx,
    input  logic [7:0]                        name_char,
    input  logic [$clog2(NAME_CHARS+1)-1:0]   name_len,
    odcd_out_if.source                        res
);
    import odcd_pkg::*;

    localparam int IW  = $clog2(NAME_CHARS);
    localparam int NLW = $clog2(NAME_CHARS + 1);

    logic [NLW-1:0] step_reg, step_next;
    logic [NLW-1:0] name_count;
    logic [NLW-1:0] name_pos;
    logic [NLW-1:0] fetch_pos;
    logic           use_default;

    logic           valid_reg, valid_next;
    kind_t          kind_reg, kind_next;
    logic [7:0]     data_reg, data_next;
    logic [30:0]    size_reg, size_next;
    logic           end_reg, end_next;
    logic           lost_reg, lost_next;
    logic           last_reg, last_next;

    logic           load;

    assign load        = !valid_reg || res.ready;
    assign use_default = (name_len == '0);
    assign name_count  = use_default ? NLW'(DEFAULT_NAME_LEN) : name_len;
    assign name_pos    = step_reg - NLW'(1);
    // The name store read is registered, so the position for the next step is
    // addressed in the cycle before its use.
    assign fetch_pos   = step_next - NLW'(1);
    assign name_rd_idx = fetch_pos[IW-1:0];

    always_comb
    begin
        step_next  = step_reg;
        valid_next = valid_reg && !res.ready;
        kind_next  = kind_reg;
        data_next  = data_reg;
        size_next  = size_reg;
        end_next   = end_reg;
        lost_next  = lost_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        start_done = 1'b0;

        if (head_valid && load)
        begin
            valid_next = 1'b1;
            size_next  = '0;
            end_next   = 1'b0;
            lost_next  = 1'b0;
            case (head_cmd.ctype)
                CMD_SINGLE:
                begin
                    kind_next = head_cmd.kind;
                    data_next = head_cmd.data;
                    end_next  = head_cmd.body_end;
                    lost_next = head_cmd.lost;
                    last_next = 1'b1;
                    pop       = 1'b1;
                end
                CMD_ESC_PAIR:
                begin
                    kind_next = KIND_CONSOLE;
                    if (step_reg == '0)
                    begin
                        data_next = BYTE_ESC;
                        last_next = 1'b0;
                        step_next = NLW'(1);
                    end
                    else
                    begin
                        data_next = head_cmd.data;
                        last_next = 1'b1;
                        step_next = '0;
                        pop       = 1'b1;
                    end
                end
                CMD_START:
                begin
                    if (step_reg == '0)
                    begin
                        kind_next = KIND_START;
                        data_next = 8'd0;
                        size_next = head_cmd.size;
                        last_next = 1'b0;
                        step_next = NLW'(1);
                    end
                    else
                    begin
                        kind_next = KIND_NAME;
                        data_next = use_default ? default_name_char(name_pos[2:0]) : name_char;
                        last_next = (step_reg == name_count);
                        if (step_reg == name_count)
                        begin
                            step_next  = '0;
                            pop        = 1'b1;
                            start_done = 1'b1;
                        end
                        else
                        begin
                            step_next = step_reg + NLW'(1);
                        end
                    end
                end
                default:
                begin
                    valid_next = 1'b0;
                    pop        = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        data_reg <= data_next;
        size_reg <= size_next;
        end_reg  <= end_next;
        lost_reg <= lost_next;
        last_reg <= last_next;
    end

    assign res.valid        = valid_reg;
    assign res.kind         = 2'(kind_reg);
    assign res.data_byte    = data_reg;
    assign res.body_size    = size_reg;
    assign res.body_end     = end_reg;
    assign res.carrier_lost = lost_reg;
    assign res.last         = last_reg;

endmodule

@@ src/osc_download_capture_deframer.sv @@
`timescale 1ns / 1ps

// Channel  Direction  Payload
// rx       in         rx_byte[7:0]
// res      out        kind[1:0], data_byte[7:0], body_size[30:0], body_end,
//                     carrier_lost, last
//
// Each received byte is classified by the front end and, if it yields results,
// turns into one command in a two-entry queue. The back end turns a command
// into one result per cycle from its output register while res is ready: one
// for a console or body byte, two for an escape pass-through, and one start
// plus one to NAME_CHARS name characters (eight for the default name) for a
// download. Input bytes flow at one per cycle while the queue has room; after
// a download start, input is held off until the back end has read the whole
// name run, since the name store is read in place. Reset is asynchronous
// and active low and clears all control state; the name store is not cleared.
module osc_download_capture_deframer #(
    parameter int HEADER_CAP = odcd_pkg::HEADER_CAP_DEF,
    parameter int NAME_CHARS = odcd_pkg::NAME_CHARS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    odcd_in_if.sink    rx,
    odcd_out_if.source res
);
    import odcd_pkg::*;

    localparam int IW  = $clog2(NAME_CHARS);
    localparam int NLW = $clog2(NAME_CHARS + 1);

    // Command path from the front end through the queue to the back end.
    logic     q_ready;
    logic     q_push;
    cmd_t     q_cmd;
    logic     q_pop;
    logic     q_head_valid;
    cmd_t     q_head_cmd;

    // The back end reads the name in place and reports when a start is done.
    logic           start_done;
    logic [IW-1:0]  name_rd_idx;
    logic [7:0]     name_char;
    logic [NLW-1:0] name_len;

    odcd_front #(
        .HEADER_CAP (HEADER_CAP),
        .NAME_CHARS (NAME_CHARS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx          (rx),
        .q_ready     (q_ready),
        .q_push      (q_push),
        .q_cmd       (q_cmd),
        .start_done  (start_done),
        .name_rd_idx (name_rd_idx),
        .name_char   (name_char),
        .name_len    (name_len)
    );

    odcd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .push_ready (q_ready),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd)
    );

    odcd_back #(
        .NAME_CHARS (NAME_CHARS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (q_head_valid),
        .head_cmd    (q_head_cmd),
        .pop         (q_pop),
        .start_done  (start_done),
        .name_rd_idx (name_rd_idx),
        .name_char   (name_char),
        .name_len    (name_len),
        .res         (res)
    );

endmodule
